FILE: src/sli_pkg.sv
// Shared types and constants for the sorted list insert/delete core.
// Used by sli_ctrl, sli_datapath and sorted_list_insert_delete_core; no dependencies.
`default_nettype none

package sli_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int MODE_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 5;
    localparam int S_TDATA_W    = 32;
    localparam int M_TDATA_W    = 40;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic dump_step;
    } sli_cmd_t;

    typedef struct packed {
        logic              out_free;
        logic [MODE_W-1:0] mode;
        logic              empty;
        logic              dump_last;
    } sli_stat_t;

endpackage

`default_nettype wire

FILE: src/sli_ctrl.sv
// Controller state machine of the sorted list core.
// Depends on sli_pkg; drives the command struct of sli_datapath.
`default_nettype none

module sli_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire sli_pkg::sli_stat_t stat,
    output sli_pkg::sli_cmd_t      cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.load_item = 1'b0;
        cmd.exec      = 1'b0;
        cmd.dump_step = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.out_free) begin
                    if (stat.mode == sli_pkg::MODE_DUMP && !stat.empty) begin
                        cmd.dump_step = 1'b1;
                        state_next    = stat.dump_last ? S_IDLE : S_DUMP;
                    end else begin
                        cmd.exec   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_DUMP: begin
                if (stat.out_free) begin
                    cmd.dump_step = 1'b1;
                    if (stat.dump_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/sli_datapath.sv
// Datapath of the sorted list core: a row of compare-and-shift cells, the entry
// count, the dump counter and the output register. Depends on sli_pkg.
`default_nettype none

module sli_datapath #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire sli_pkg::sli_cmd_t                 cmd,
    output sli_pkg::sli_stat_t                     stat,
    input  wire logic [sli_pkg::MODE_W-1:0]        in_mode,
    input  wire logic signed [sli_pkg::VALUE_W-1:0] in_value,
    output logic signed [sli_pkg::VALUE_W-1:0]     out_value,
    output logic [sli_pkg::STATUS_W-1:0]           out_status,
    output logic [sli_pkg::COUNT_OUT_W-1:0]        out_count,
    output logic                                   out_last,
    output logic                                   out_valid,
    input  wire logic                              out_ready
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [sli_pkg::MODE_W-1:0]          mode_reg;
    logic signed [sli_pkg::VALUE_W-1:0]  value_reg;
    logic signed [sli_pkg::VALUE_W-1:0]  cells_reg  [CAPACITY];
    logic signed [sli_pkg::VALUE_W-1:0]  cells_next [CAPACITY];
    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       count_next;
    logic [CW-1:0]                       idx_reg;
    logic [CW-1:0]                       idx_next;
    logic [CW-1:0]                       count_m1;

    logic signed [sli_pkg::VALUE_W-1:0]  out_value_reg;
    logic signed [sli_pkg::VALUE_W-1:0]  out_value_next;
    logic [sli_pkg::STATUS_W-1:0]        out_status_reg;
    logic [sli_pkg::STATUS_W-1:0]        out_status_next;
    logic [sli_pkg::COUNT_OUT_W-1:0]     out_count_reg;
    logic [sli_pkg::COUNT_OUT_W-1:0]     out_count_next;
    logic                                out_last_reg;
    logic                                out_last_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;

    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] eq;
    logic                found;
    logic                full;
    logic                empty;
    logic                ins_en;
    logic                del_en;
    logic                rot_en;
    logic                out_free;

    assign count_m1 = count_reg - CW'(1);
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);
    assign found    = |eq;
    assign out_free = !out_valid_reg || out_ready;

    assign ins_en = cmd.exec && (mode_reg == sli_pkg::MODE_INSERT) && !full;
    assign del_en = cmd.exec && (mode_reg == sli_pkg::MODE_DELETE) && found;
    assign rot_en = cmd.dump_step;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [sli_pkg::VALUE_W-1:0] up_val;
        logic signed [sli_pkg::VALUE_W-1:0] ins_val;
        logic                               in_range;

        assign in_range = (CW'(i) < count_reg);
        assign lt[i]    = in_range && (cells_reg[i] < value_reg);
        assign eq[i]    = in_range && (cells_reg[i] == value_reg);

        if (i == CAPACITY - 1) begin : g_top
            assign up_val = cells_reg[i];
        end else begin : g_mid
            assign up_val = cells_reg[i + 1];
        end

        if (i == 0) begin : g_first
            assign ins_val = value_reg;
        end else begin : g_rest
            assign ins_val = lt[i - 1] ? value_reg : cells_reg[i - 1];
        end

        always_comb begin
            cells_next[i] = cells_reg[i];
            if (ins_en && !lt[i]) begin
                cells_next[i] = ins_val;
            end else if (del_en && !lt[i]) begin
                cells_next[i] = up_val;
            end else if (rot_en) begin
                if (CW'(i) < count_m1) begin
                    cells_next[i] = up_val;
                end else if (CW'(i) == count_m1) begin
                    cells_next[i] = cells_reg[0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            cells_reg[i] <= cells_next[i];
        end
    end

    always_comb begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (ins_en) begin
            count_next = count_reg + CW'(1);
        end else if (del_en) begin
            count_next = count_m1;
        end

        if (cmd.load_item) begin
            idx_next = '0;
        end else if (rot_en) begin
            idx_next = idx_reg + CW'(1);
        end

        if (cmd.exec) begin
            out_value_next = '0;
            out_last_next  = 1'b1;
            out_valid_next = 1'b1;
            out_count_next = sli_pkg::COUNT_OUT_W'(count_next);
            case (mode_reg)
                sli_pkg::MODE_INSERT: begin
                    out_status_next = full ? sli_pkg::ST_FULL : sli_pkg::ST_OK;
                end
                sli_pkg::MODE_DELETE: begin
                    if (empty) begin
                        out_status_next = sli_pkg::ST_EMPTY;
                    end else if (!found) begin
                        out_status_next = sli_pkg::ST_NOT_FOUND;
                    end else begin
                        out_status_next = sli_pkg::ST_OK;
                    end
                end
                sli_pkg::MODE_DUMP: begin
                    out_status_next = sli_pkg::ST_EMPTY;
                end
                default: begin
                    out_status_next = sli_pkg::ST_OK;
                end
            endcase
        end else if (rot_en) begin
            out_value_next  = cells_reg[0];
            out_status_next = sli_pkg::ST_OK;
            out_count_next  = sli_pkg::COUNT_OUT_W'(count_reg);
            out_last_next   = (idx_reg == count_m1);
            out_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            mode_reg  <= in_mode;
            value_reg <= in_value;
        end
        idx_reg        <= idx_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_last_reg   <= out_last_next;
    end

    assign stat.out_free  = out_free;
    assign stat.mode      = mode_reg;
    assign stat.empty     = empty;
    assign stat.dump_last = (idx_reg == count_m1);

    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;
    assign out_last   = out_last_reg;
    assign out_valid  = out_valid_reg;

endmodule

`default_nettype wire

FILE: src/sorted_list_insert_delete_core.sv
// Top level of the sorted list core: ascending store of signed 32-bit values.
// Depends on sli_pkg, sli_ctrl and sli_datapath.
//
// Input stream: s_tuser carries the operation (insert, delete, dump), s_tdata the
// value. Output stream: m_tdata carries value, status and entry count; m_tlast
// marks the final word caused by an input word.
// An insert or delete runs in a row of compare-and-shift cells and gives one
// word; the accepted input word is registered, the result is written to the
// output register once it is free, and only then is the next input word taken,
// so the core does not take a new word before it is through with the last.
// A dump rotates the cells by one position per cycle and emits the head cell,
// one word per cycle while the output register is free; an empty store gives
// a single word with the empty status.
// The output register decouples the sides: a new input word is accepted while
// a result still waits. When the receiver stalls, the core holds its result
// and the next operation waits for the output register to drain.
// Reset empties the store and drops the output valid; no clearing pass is needed.
`default_nettype none

module sorted_list_insert_delete_core #(
    parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [31:0] item_value
    input  wire logic [sli_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  wire logic [sli_pkg::MODE_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] out_value, [33:32] status, [38:34] entry_count, [39] zero
    output logic [sli_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                m_tlast
);

    sli_pkg::sli_cmd_t  cmd;
    sli_pkg::sli_stat_t stat;

    logic signed [sli_pkg::VALUE_W-1:0] out_value;
    logic [sli_pkg::STATUS_W-1:0]       out_status;
    logic [sli_pkg::COUNT_OUT_W-1:0]    out_count;

    sli_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sli_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_mode    (s_tuser),
        .in_value   (s_tdata),
        .out_value  (out_value),
        .out_status (out_status),
        .out_count  (out_count),
        .out_last   (m_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

    assign m_tdata = {1'b0, out_count, out_status, out_value};

    a_one_item_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while an item is still in progress");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33:32] == sli_pkg::ST_FULL)
            |-> (m_tdata[38:34] == sli_pkg::COUNT_OUT_W'(CAPACITY)))
        else $error("full status reported with a count below capacity");

    a_only_dump_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[33:32] == sli_pkg::ST_OK))
        else $error("non-final result word without ok status");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for sorted_list_insert_delete_core: a shadow sorted list predicts
// every output word; directed, fill-to-full and random traffic run, mostly with stalls.
// Depends on sli_pkg and the RTL of the core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY = sli_pkg::CAPACITY_DEF;
    localparam logic [sli_pkg::MODE_W-1:0] MODE_NOP = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        logic [sli_pkg::VALUE_W-1:0]     value;
        logic [sli_pkg::STATUS_W-1:0]    status;
        logic [sli_pkg::COUNT_OUT_W-1:0] count;
        logic                            last;
    } result_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [sli_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [sli_pkg::MODE_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [sli_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tlast;

    logic signed [sli_pkg::VALUE_W-1:0] shadow_list[$];
    result_word_t pending_words[$];
    int error_count = 0;
    int quiet_cycles = 0;
    int ready_left = 0;
    logic idle_on = 1'b1;

    sorted_list_insert_delete_core dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    task automatic expect_word(input logic [sli_pkg::VALUE_W-1:0] value,
                               input logic [sli_pkg::STATUS_W-1:0] status,
                               input logic last);
        result_word_t w;
        w.value = value;
        w.status = status;
        w.count = sli_pkg::COUNT_OUT_W'(shadow_list.size());
        w.last = last;
        pending_words.push_back(w);
    endtask

    task automatic apply_operation(input logic [sli_pkg::MODE_W-1:0] op,
                                   input logic signed [sli_pkg::VALUE_W-1:0] val);
        int pos;
        pos = 0;
        case (op)
            sli_pkg::MODE_INSERT: begin
                if (shadow_list.size() >= CAPACITY) begin
                    expect_word('0, sli_pkg::ST_FULL, 1'b1);
                end else begin
                    while (pos < shadow_list.size() && shadow_list[pos] < val) pos++;
                    shadow_list.insert(pos, val);
                    expect_word('0, sli_pkg::ST_OK, 1'b1);
                end
            end
            sli_pkg::MODE_DELETE: begin
                if (shadow_list.size() == 0) begin
                    expect_word('0, sli_pkg::ST_EMPTY, 1'b1);
                end else begin
                    while (pos < shadow_list.size() && shadow_list[pos] != val) pos++;
                    if (pos >= shadow_list.size()) begin
                        expect_word('0, sli_pkg::ST_NOT_FOUND, 1'b1);
                    end else begin
                        shadow_list.delete(pos);
                        expect_word('0, sli_pkg::ST_OK, 1'b1);
                    end
                end
            end
            sli_pkg::MODE_DUMP: begin
                if (shadow_list.size() == 0) begin
                    expect_word('0, sli_pkg::ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < shadow_list.size(); i++)
                        expect_word(shadow_list[i], sli_pkg::ST_OK,
                                    i == shadow_list.size() - 1);
                end
            end
            default: begin
                expect_word('0, sli_pkg::ST_OK, 1'b1);
            end
        endcase
    endtask

    task automatic send_word(input logic [sli_pkg::MODE_W-1:0] op,
                             input logic [sli_pkg::VALUE_W-1:0] val);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= val;
        do @(posedge aclk); while (!s_tready);
        apply_operation(op, val);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [sli_pkg::VALUE_W-1:0] random_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return $urandom();
        if (roll < 70) return $urandom_range(0, 8) - 4;
        if (roll < 85) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7fff_ffff;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        if (shadow_list.size() != 0) return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        return $urandom();
    endfunction

    function automatic logic [sli_pkg::VALUE_W-1:0] delete_value();
        if (shadow_list.size() != 0 && $urandom_range(0, 3) != 0)
            return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        return random_value();
    endfunction

    task automatic test_empty_store();
        send_word(sli_pkg::MODE_DUMP, $urandom());
        send_word(sli_pkg::MODE_DELETE, 32'h0000_0000);
        send_word(MODE_NOP, $urandom());
    endtask

    task automatic test_order_and_duplicates();
        send_word(sli_pkg::MODE_INSERT, 32'h7fff_ffff);
        send_word(sli_pkg::MODE_INSERT, 32'h8000_0000);
        send_word(sli_pkg::MODE_INSERT, 32'h0000_0000);
        send_word(sli_pkg::MODE_INSERT, 32'hffff_ffff);
        send_word(sli_pkg::MODE_INSERT, 32'h0000_0000);
        send_word(sli_pkg::MODE_INSERT, 32'h0000_0001);
        send_word(sli_pkg::MODE_DUMP, 32'hffff_ffff);
        send_word(sli_pkg::MODE_DELETE, 32'h0000_0005);
        send_word(sli_pkg::MODE_DELETE, 32'h0000_0000);
        send_word(sli_pkg::MODE_DELETE, 32'h8000_0000);
        send_word(sli_pkg::MODE_DELETE, 32'h7fff_ffff);
        send_word(sli_pkg::MODE_DUMP, 32'h0000_0000);
        send_word(MODE_NOP, 32'ha5a5_5a5a);
    endtask

    // The sender holds off first, so the fill starts from a quiet core.
    task automatic test_full_store();
        wait_drained();
        while (shadow_list.size() < CAPACITY) send_word(sli_pkg::MODE_INSERT, random_value());
        send_word(sli_pkg::MODE_INSERT, random_value());
        send_word(sli_pkg::MODE_DUMP, $urandom());
        while (shadow_list.size() != 0) send_word(sli_pkg::MODE_DELETE, delete_value());
        send_word(sli_pkg::MODE_DELETE, random_value());
        send_word(sli_pkg::MODE_DUMP, $urandom());
    endtask

    // Traffic alternates between a growing and a shrinking phase so that the list
    // sweeps between empty and full with random content.
    task automatic test_random_traffic(input int n_items, input bit allow_idle);
        logic [sli_pkg::MODE_W-1:0] op;
        int roll;
        bit growing;
        growing = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (allow_idle && i % 40 == 0) idle_on <= ($urandom_range(0, 3) != 0);
            if (i % 100 == 99) wait_drained();
            if (shadow_list.size() == CAPACITY && $urandom_range(0, 2) == 0) growing = 1'b0;
            if (shadow_list.size() == 0) growing = 1'b1;
            if ($urandom_range(0, 29) == 0) growing = !growing;
            roll = $urandom_range(0, 99);
            if (roll < (growing ? 60 : 20)) op = sli_pkg::MODE_INSERT;
            else if (roll < (growing ? 82 : 80)) op = sli_pkg::MODE_DELETE;
            else if (roll < (growing ? 95 : 93)) op = sli_pkg::MODE_DUMP;
            else op = MODE_NOP;
            send_word(op, op == sli_pkg::MODE_DELETE ? delete_value() :
                          op == sli_pkg::MODE_INSERT ? random_value() : $urandom());
        end
    endtask

    task automatic test_steady_stream();
        idle_on <= 1'b0;
        test_random_traffic(40, 1'b0);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_store();
        test_order_and_duplicates();
        test_full_store();
        test_random_traffic(330, 1'b1);
        test_steady_stream();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    always @(posedge aclk) begin
        if (!idle_on) begin
            m_tready <= 1'b1;
            ready_left <= 0;
        end else if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 2) != 0);
            ready_left <= $urandom_range(0, 9);
        end
    end

    task automatic report_mismatch(input string what, input logic [sli_pkg::VALUE_W-1:0] want,
                                   input logic [sli_pkg::VALUE_W-1:0] got);
        error_count++;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endtask

    always @(posedge aclk) begin : check_words
        result_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                error_count++;
                $display("%0t ns: word with no expectation, expected none, actual %h last %b",
                         $time, m_tdata, m_tlast);
            end else begin
                want = pending_words.pop_front();
                if (m_tdata[31:0] !== want.value)
                    report_mismatch("out_value", want.value, m_tdata[31:0]);
                if (m_tdata[33:32] !== want.status)
                    report_mismatch("status", sli_pkg::VALUE_W'(want.status),
                                    sli_pkg::VALUE_W'(m_tdata[33:32]));
                if (m_tdata[38:34] !== want.count)
                    report_mismatch("entry_count", sli_pkg::VALUE_W'(want.count),
                                    sli_pkg::VALUE_W'(m_tdata[38:34]));
                if (m_tdata[39] !== 1'b0)
                    report_mismatch("pad bit", '0, sli_pkg::VALUE_W'(m_tdata[39]));
                if (m_tlast !== want.last)
                    report_mismatch("last", sli_pkg::VALUE_W'(want.last),
                                    sli_pkg::VALUE_W'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end
endmodule

FILE: sim.f
src/sli_pkg.sv
src/sli_ctrl.sv
src/sli_datapath.sv
src/sorted_list_insert_delete_core.sv
bench/testbench.sv
